@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the interrupt priority resolver top level.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on the rising edge, off during reset
`define IPR_ASSERT_IMP(lbl, ck, rn, a, c) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (a) |-> (c)) \
	else $error("same-cycle implication violated");

// Next-cycle implication, sampled on the rising edge, off during reset
`define IPR_ASSERT_NXT(lbl, ck, rn, a, c) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (a) |=> (c)) \
	else $error("next-cycle implication violated");

`else

`define IPR_ASSERT_IMP(lbl, ck, rn, a, c)
`define IPR_ASSERT_NXT(lbl, ck, rn, a, c)

`endif

`endif

@@ rtl/core/ipr_pkg.sv @@
// Package for the interrupt priority resolver: command codes, level codes,
// the resolve decision struct and the priority encoder. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ipr_pkg;

	// Command codes of an input word
	typedef logic [1:0] cmd_t;
	localparam cmd_t CMD_RAISE     = 2'd0;
	localparam cmd_t CMD_RESOLVE   = 2'd1;
	localparam cmd_t CMD_WRITE_ISR = 2'd2;

	// Delivered priority levels
	typedef logic [2:0] level_t;
	localparam level_t LVL_NONE   = 3'd0;
	localparam level_t LVL_HSYNC  = 3'd2;
	localparam level_t LVL_VSYNC  = 3'd4;
	localparam level_t LVL_PERIPH = 3'd6;

	// Configuration register indexes
	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_ENABLE_MASK  = 2'd0;
	localparam cfg_idx_t CFG_UNMASK_BITS  = 2'd1;
	localparam cfg_idx_t CFG_VECTOR_BASE  = 2'd2;
	localparam cfg_idx_t CFG_SOFTWARE_EOI = 2'd3;

	localparam int SRC_W  = 16;
	localparam int IDX_W  = 4;
	localparam int BASE_W = 4;
	localparam int VEC_W  = 8;
	localparam int CFG_W  = 16;

	// Resolve outcome handed from the decision logic to the state update
	typedef struct packed {
		logic             periph;
		logic             vsync;
		logic             hsync;
		logic [IDX_W-1:0] idx;
	} resolve_t;

	// Index of the highest set bit; zero when none is set
	function automatic logic [IDX_W-1:0] top_index(input logic [SRC_W-1:0] v);
		logic [IDX_W-1:0] r;
		r = '0;
		for (int i = 0; i < SRC_W; i++) begin
			if (v[i]) r = IDX_W'(i);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/ipr_resolve.sv @@
// Resolve decision: peripheral priority test and sync autovector fallback.
// Depends on ipr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ipr_resolve import ipr_pkg::*; (
	input  logic             active,
	input  logic [SRC_W-1:0] req,
	input  logic [SRC_W-1:0] isr_bits,
	input  logic [2:0]       cpu_level,
	input  logic             vsync_latch,
	input  logic             hsync_latch,
	output resolve_t         dec
);

	logic periph_ok;
	logic vsync_ok;

	// Peripheral wins below CPU level 6 if it outranks everything in service
	assign periph_ok = active && (cpu_level < 3'd6) && (req > isr_bits);
	assign vsync_ok  = active && !periph_ok && vsync_latch && (cpu_level < 3'd4);

	always_comb begin
		dec.periph = periph_ok;
		dec.vsync  = vsync_ok;
		dec.hsync  = active && !periph_ok && !vsync_ok && hsync_latch
			&& (cpu_level < 3'd2);
		dec.idx    = top_index(req);
	end

endmodule

`default_nettype wire

@@ rtl/core/ipr_state.sv @@
// Pending, in-service and sync latch registers with their update logic.
// Depends on ipr_pkg and ipr_resolve.
`timescale 1ns / 1ps
`default_nettype none

module ipr_state import ipr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  cmd_t              cmd,
	input  logic [SRC_W-1:0]  source_bits,
	input  logic              vsync_event,
	input  logic              hsync_event,
	input  logic [2:0]        cpu_level,
	input  logic [SRC_W-1:0]  service_value,
	input  logic [SRC_W-1:0]  enable_mask,
	input  logic [SRC_W-1:0]  unmask_bits,
	input  logic              software_eoi,
	output resolve_t          dec,
	output logic [SRC_W-1:0]  pending_nx,
	output logic [SRC_W-1:0]  isr_nx
);

	localparam int HALF = SRC_W / 2;

	logic [SRC_W-1:0] pending_q;
	logic [SRC_W-1:0] isr_q;
	logic             vsync_q;
	logic             hsync_q;
	logic [SRC_W-1:0] raised;
	logic [SRC_W-1:0] hit;
	logic             vsync_nx;
	logic             hsync_nx;

	ipr_resolve u_resolve (
		.active      (cmd == CMD_RESOLVE),
		.req         (pending_q & unmask_bits),
		.isr_bits    (isr_q),
		.cpu_level   (cpu_level),
		.vsync_latch (vsync_q),
		.hsync_latch (hsync_q),
		.dec         (dec)
	);

	// Each byte half with a source bit is merged and masked by its enables
	always_comb begin
		raised = pending_q;
		if (source_bits[SRC_W-1:HALF] != '0)
			raised[SRC_W-1:HALF] = (pending_q[SRC_W-1:HALF] | source_bits[SRC_W-1:HALF])
				& enable_mask[SRC_W-1:HALF];
		if (source_bits[HALF-1:0] != '0)
			raised[HALF-1:0] = (pending_q[HALF-1:0] | source_bits[HALF-1:0])
				& enable_mask[HALF-1:0];
	end

	assign hit = SRC_W'(1) << dec.idx;

	// Next state for the word in hand
	always_comb begin
		pending_nx = pending_q;
		isr_nx     = isr_q;
		vsync_nx   = vsync_q;
		hsync_nx   = hsync_q;
		case (cmd)
			CMD_RAISE: begin
				pending_nx = raised;
				vsync_nx   = vsync_q | vsync_event;
				hsync_nx   = hsync_q | hsync_event;
			end
			CMD_RESOLVE: begin
				if (dec.periph) begin
					pending_nx = pending_q & ~hit;
					isr_nx     = software_eoi ? (isr_q | hit)
						: (isr_q & ~hit);
				end
				if (dec.vsync) vsync_nx = 1'b0;
				if (dec.hsync) hsync_nx = 1'b0;
			end
			CMD_WRITE_ISR: begin
				isr_nx = service_value;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			isr_q     <= '0;
			vsync_q   <= 1'b0;
			hsync_q   <= 1'b0;
		end else if (go) begin
			pending_q <= pending_nx;
			isr_q     <= isr_nx;
			vsync_q   <= vsync_nx;
			hsync_q   <= hsync_nx;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/interrupt_priority_resolver.sv @@
// Interrupt priority resolver top level: input register, config registers,
// result register. Depends on ipr_pkg, ipr_state and assert_macros.svh.
//
// Usage: command words enter on the in channel (in_valid / in_stall) and one
// result word per command leaves on the out channel (out_valid / out_stall).
// A raise word sets pending bits and sync latches, a resolve word delivers the
// best interrupt (level 6 vectored, 4 vsync, 2 hsync autovector), a write word
// loads the in-service bits. Every result carries pending and in-service bits.
// Path: an accepted word is held in the input register, then the state update
// and result register take it together and out_valid rises. Throughput: one
// word per cycle while out_stall does not hold a waiting result; the state
// registers are updated in the same cycle the result is registered.
// Stall: while out_stall holds a waiting result, the word in the input
// register waits and in_stall rises; one word can sit in each register.
// Reset: arst_n clears pending, in-service, both latches, all configuration
// registers and the valid flags. Configuration writes (cfg_we, cfg_index,
// cfg_data) take effect at the clock edge and belong in idle periods.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module interrupt_priority_resolver import ipr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// configuration
	input  logic              cfg_we,
	input  cfg_idx_t          cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	// input channel
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        cmd,
	input  logic [SRC_W-1:0]  source_bits,
	input  logic              vsync_event,
	input  logic              hsync_event,
	input  logic [2:0]        cpu_level,
	input  logic [SRC_W-1:0]  service_value,
	// output channel
	output logic              out_valid,
	input  logic              out_stall,
	output logic              irq_taken,
	output logic [2:0]        irq_level,
	output logic [VEC_W-1:0]  irq_vector,
	output logic [SRC_W-1:0]  pending_now,
	output logic [SRC_W-1:0]  in_service_now
);

	logic [SRC_W-1:0]  enable_mask_q;
	logic [SRC_W-1:0]  unmask_bits_q;
	logic [BASE_W-1:0] vector_base_q;
	logic              software_eoi_q;

	logic              valid_s1;
	cmd_t              cmd_s1;
	logic [SRC_W-1:0]  source_bits_s1;
	logic              vsync_event_s1;
	logic              hsync_event_s1;
	logic [2:0]        cpu_level_s1;
	logic [SRC_W-1:0]  service_value_s1;

	logic              out_valid_q;
	logic              advance;
	resolve_t          dec;
	logic [SRC_W-1:0]  pending_nx;
	logic [SRC_W-1:0]  isr_nx;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_mask_q  <= '0;
			unmask_bits_q  <= '0;
			vector_base_q  <= '0;
			software_eoi_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ENABLE_MASK:  enable_mask_q  <= cfg_data;
				CFG_UNMASK_BITS:  unmask_bits_q  <= cfg_data;
				CFG_VECTOR_BASE:  vector_base_q  <= cfg_data[BASE_W-1:0];
				CFG_SOFTWARE_EOI: software_eoi_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Handshake: the input register moves on when the result slot is free
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			cmd_s1           <= cmd;
			source_bits_s1   <= source_bits;
			vsync_event_s1   <= vsync_event;
			hsync_event_s1   <= hsync_event;
			cpu_level_s1     <= cpu_level;
			service_value_s1 <= service_value;
		end
	end

	ipr_state u_state (
		.clk           (clk),
		.arst_n        (arst_n),
		.go            (advance),
		.cmd           (cmd_s1),
		.source_bits   (source_bits_s1),
		.vsync_event   (vsync_event_s1),
		.hsync_event   (hsync_event_s1),
		.cpu_level     (cpu_level_s1),
		.service_value (service_value_s1),
		.enable_mask   (enable_mask_q),
		.unmask_bits   (unmask_bits_q),
		.software_eoi  (software_eoi_q),
		.dec           (dec),
		.pending_nx    (pending_nx),
		.isr_nx        (isr_nx)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			irq_taken      <= dec.periph | dec.vsync | dec.hsync;
			irq_level      <= dec.periph ? LVL_PERIPH
				: dec.vsync ? LVL_VSYNC
				: dec.hsync ? LVL_HSYNC : LVL_NONE;
			irq_vector     <= dec.periph ? {vector_base_q, dec.idx} : '0;
			pending_now    <= pending_nx;
			in_service_now <= isr_nx;
		end
	end

	assign out_valid = out_valid_q;

	// Checks
	`IPR_ASSERT_IMP(a_taken_level, clk, arst_n, out_valid_q && irq_taken, (irq_level == LVL_PERIPH || irq_level == LVL_VSYNC || irq_level == LVL_HSYNC))
	`IPR_ASSERT_IMP(a_idle_result, clk, arst_n, out_valid_q && !irq_taken, (irq_level == LVL_NONE && irq_vector == '0))
	`IPR_ASSERT_IMP(a_stall_cause, clk, arst_n, in_stall, (valid_s1 && out_valid_q && out_stall))
	`IPR_ASSERT_NXT(a_advance_out, clk, arst_n, advance, out_valid_q)

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// Self-checking testbench for interrupt_priority_resolver: directed words, then random
// raise/resolve/write/spare words over several register settings, checked by a scoreboard.
// Depends on ipr_pkg for command, level and register index codes.
`timescale 1ns / 1ps

import ipr_pkg::*;

// One result word as seen on the output channel
typedef struct packed {
	logic             taken;
	level_t           level;
	logic [VEC_W-1:0] vector;
	logic [SRC_W-1:0] pend;
	logic [SRC_W-1:0] isr;
} irq_result_t;

// Tracks the resolver state and the queue of expected result words
class irq_scoreboard;
	logic [SRC_W-1:0]  enable_mask;
	logic [SRC_W-1:0]  unmask_bits;
	logic [BASE_W-1:0] vector_base;
	logic              sw_eoi;
	logic [SRC_W-1:0]  pending;
	logic [SRC_W-1:0]  isr_bits;
	logic              vsync_seen;
	logic              hsync_seen;
	irq_result_t       expected_q[$];
	int                errors;
	int                n_words;
	int                checked;
	int                n_periph;
	int                n_vsync;
	int                n_hsync;

	function new();
		enable_mask = '0;
		unmask_bits = '0;
		vector_base = '0;
		sw_eoi      = 1'b0;
		pending     = '0;
		isr_bits    = '0;
		vsync_seen  = 1'b0;
		hsync_seen  = 1'b0;
		errors      = 0;
		n_words     = 0;
		checked     = 0;
		n_periph    = 0;
		n_vsync     = 0;
		n_hsync     = 0;
	endfunction

	function void write_reg(cfg_idx_t idx, logic [CFG_W-1:0] d);
		case (idx)
			CFG_ENABLE_MASK:  enable_mask = d;
			CFG_UNMASK_BITS:  unmask_bits = d;
			CFG_VECTOR_BASE:  vector_base = d[BASE_W-1:0];
			CFG_SOFTWARE_EOI: sw_eoi      = d[0];
			default: ;
		endcase
	endfunction

	// Apply one accepted word to the state and queue the result it must give
	function void note_word(cmd_t c, logic [SRC_W-1:0] src, logic vs, logic hs,
			logic [2:0] lvl, logic [SRC_W-1:0] sv);
		irq_result_t      r;
		logic [SRC_W-1:0] req;
		logic [IDX_W-1:0] idx;
		r = '0;
		idx = '0;
		n_words++;
		case (c)
			CMD_RAISE: begin
				// each byte half is only touched when it carries source bits
				if (src[15:8] != 8'h00)
					pending[15:8] = (pending[15:8] | src[15:8]) & enable_mask[15:8];
				if (src[7:0] != 8'h00)
					pending[7:0] = (pending[7:0] | src[7:0]) & enable_mask[7:0];
				if (vs) vsync_seen = 1'b1;
				if (hs) hsync_seen = 1'b1;
			end
			CMD_RESOLVE: begin
				req = pending & unmask_bits;
				if (lvl < LVL_PERIPH && req > isr_bits) begin
					for (int i = SRC_W - 1; i >= 0; i--) begin
						if (req[i]) begin
							idx = IDX_W'(i);
							break;
						end
					end
					if (sw_eoi) isr_bits[idx] = 1'b1;
					else        isr_bits[idx] = 1'b0;
					pending[idx] = 1'b0;
					r.taken  = 1'b1;
					r.level  = LVL_PERIPH;
					r.vector = {vector_base, idx};
					n_periph++;
				end else if (vsync_seen && lvl < LVL_VSYNC) begin
					vsync_seen = 1'b0;
					r.taken = 1'b1;
					r.level = LVL_VSYNC;
					n_vsync++;
				end else if (hsync_seen && lvl < LVL_HSYNC) begin
					hsync_seen = 1'b0;
					r.taken = 1'b1;
					r.level = LVL_HSYNC;
					n_hsync++;
				end
			end
			CMD_WRITE_ISR: isr_bits = sv;
			default: ;
		endcase
		r.pend = pending;
		r.isr  = isr_bits;
		expected_q.push_back(r);
	endfunction

	function void check_word(irq_result_t got);
		irq_result_t want;
		if (expected_q.size() == 0) begin
			$error("result word with none outstanding: pending_now %h", got.pend);
			errors++;
			return;
		end
		want = expected_q.pop_front();
		checked++;
		if (got.taken !== want.taken) begin
			$error("irq_taken: expected %0d, got %0d", want.taken, got.taken);
			errors++;
		end
		if (got.level !== want.level) begin
			$error("irq_level: expected %0d, got %0d", want.level, got.level);
			errors++;
		end
		if (got.vector !== want.vector) begin
			$error("irq_vector: expected %h, got %h", want.vector, got.vector);
			errors++;
		end
		if (got.pend !== want.pend) begin
			$error("pending_now: expected %h, got %h", want.pend, got.pend);
			errors++;
		end
		if (got.isr !== want.isr) begin
			$error("in_service_now: expected %h, got %h", want.isr, got.isr);
			errors++;
		end
	endfunction
endclass

module tb;

	// spare command code, must leave the state alone
	localparam cmd_t CMD_SPARE = 2'd3;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	cfg_idx_t          cfg_index;
	logic [CFG_W-1:0]  cfg_data;
	logic              in_valid;
	logic              in_stall;
	cmd_t              cmd;
	logic [SRC_W-1:0]  source_bits;
	logic              vsync_event;
	logic              hsync_event;
	logic [2:0]        cpu_level;
	logic [SRC_W-1:0]  service_value;
	logic              out_valid;
	logic              out_stall;
	logic              irq_taken;
	logic [2:0]        irq_level;
	logic [VEC_W-1:0]  irq_vector;
	logic [SRC_W-1:0]  pending_now;
	logic [SRC_W-1:0]  in_service_now;

	irq_scoreboard sb;
	irq_result_t   got;
	bit            send_busy;
	bit            recv_busy;
	int            n_settings;

	interrupt_priority_resolver dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.cmd            (cmd),
		.source_bits    (source_bits),
		.vsync_event    (vsync_event),
		.hsync_event    (hsync_event),
		.cpu_level      (cpu_level),
		.service_value  (service_value),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.irq_taken      (irq_taken),
		.irq_level      (irq_level),
		.irq_vector     (irq_vector),
		.pending_now    (pending_now),
		.in_service_now (in_service_now)
	);

	// 8 ns clock
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Hard stop if the run hangs
	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

	// Drive one word after a random gap; returns at the edge that accepts it.
	// Valid stays high into the next call so back-to-back words need no dip.
	task automatic send_word(cmd_t c, logic [SRC_W-1:0] src, logic vs, logic hs,
			logic [2:0] lvl, logic [SRC_W-1:0] sv);
		int gap;
		gap = 0;
		if (send_busy && $urandom_range(0, 3) != 0) gap = $urandom_range(0, 15);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid      <= 1'b1;
		cmd           <= c;
		source_bits   <= src;
		vsync_event   <= vs;
		hsync_event   <= hs;
		cpu_level     <= lvl;
		service_value <= sv;
		do @(posedge clk); while (in_stall);
		sb.note_word(c, src, vs, hs, lvl, sv);
	endtask

	// Stop sending and wait for every outstanding result word
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_cfg(cfg_idx_t idx, logic [CFG_W-1:0] d);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		sb.write_reg(idx, d);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic configure(logic [CFG_W-1:0] en, logic [CFG_W-1:0] um,
			logic [CFG_W-1:0] base, logic [CFG_W-1:0] eoi);
		write_cfg(CFG_ENABLE_MASK, en);
		write_cfg(CFG_UNMASK_BITS, um);
		write_cfg(CFG_VECTOR_BASE, base);
		write_cfg(CFG_SOFTWARE_EOI, eoi);
		n_settings++;
	endtask

	// Result side: random stall before each word, none in calm phases
	initial begin : result_sink
		int hold;
		out_stall = 1'b0;
		@(negedge clk);
		forever begin
			hold = 0;
			if (recv_busy && $urandom_range(0, 3) != 0) hold = $urandom_range(0, 15);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
			@(negedge clk);
		end
	end

	// Compare every accepted result word
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			got.taken  = irq_taken;
			got.level  = irq_level;
			got.vector = irq_vector;
			got.pend   = pending_now;
			got.isr    = in_service_now;
			sb.check_word(got);
		end
	end

	// Stimulus
	initial begin
		cmd_t             c;
		logic [SRC_W-1:0] src;
		logic [SRC_W-1:0] sv;
		int               pick;

		sb            = new();
		n_settings    = 0;
		send_busy     = 1'b1;
		recv_busy     = 1'b1;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = CFG_ENABLE_MASK;
		cfg_data      = '0;
		in_valid      = 1'b0;
		cmd           = CMD_RAISE;
		source_bits   = '0;
		vsync_event   = 1'b0;
		hsync_event   = 1'b0;
		cpu_level     = '0;
		service_value = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: all sources disabled, only the sync latches can fire
		send_word(CMD_RAISE,   16'hFFFF, 1'b1, 1'b1, 3'd0, 16'h0000);
		send_word(CMD_RESOLVE, 16'h0000, 1'b0, 1'b0, 3'd7, 16'h0000);
		send_word(CMD_RESOLVE, 16'h0000, 1'b0, 1'b0, 3'd4, 16'h0000);
		send_word(CMD_RESOLVE, 16'h0000, 1'b0, 1'b0, 3'd3, 16'h0000);
		send_word(CMD_RESOLVE, 16'h0000, 1'b0, 1'b0, 3'd2, 16'h0000);
		send_word(CMD_RESOLVE, 16'h0000, 1'b0, 1'b0, 3'd1, 16'h0000);
		send_word(CMD_SPARE,   16'hFFFF, 1'b1, 1'b1, 3'd7, 16'hFFFF);

		// everything open, software end of interrupt, top vector base
		settle();
		configure(16'hFFFF, 16'hFFFF, 16'h000F, 16'h0001);
		send_word(CMD_RAISE,     16'h8001, 1'b1, 1'b0, 3'd0, 16'h0000);
		send_word(CMD_RESOLVE,   16'h0000, 1'b0, 1'b0, 3'd6, 16'h0000);
		send_word(CMD_RESOLVE,   16'h0000, 1'b0, 1'b0, 3'd5, 16'h0000);
		send_word(CMD_RESOLVE,   16'h0000, 1'b0, 1'b0, 3'd0, 16'h0000);
		send_word(CMD_WRITE_ISR, 16'h0000, 1'b0, 1'b0, 3'd0, 16'h0000);
		send_word(CMD_RESOLVE,   16'h0000, 1'b0, 1'b0, 3'd0, 16'h0000);
		send_word(CMD_RESOLVE,   16'h0000, 1'b0, 1'b0, 3'd0, 16'h0000);

		// partial enables; request equal to in-service must not be taken
		settle();
		configure(16'h0F0F, 16'h00FF, 16'h0000, 16'h0000);
		send_word(CMD_RAISE,     16'hFFFF, 1'b0, 1'b0, 3'd0, 16'h0000);
		send_word(CMD_WRITE_ISR, 16'h0000, 1'b0, 1'b0, 3'd0, 16'h000F);
		send_word(CMD_RESOLVE,   16'h0000, 1'b0, 1'b0, 3'd0, 16'h0000);
		send_word(CMD_WRITE_ISR, 16'h0000, 1'b0, 1'b0, 3'd0, 16'h0000);
		send_word(CMD_RESOLVE,   16'h0000, 1'b0, 1'b0, 3'd0, 16'h0000);
		send_word(CMD_RAISE,     16'hF000, 1'b0, 1'b0, 3'd0, 16'h0000);

		// random phases, each under its own register setting; some phases idle the sender or receiver
		for (int ph = 0; ph < 8; ph++) begin
			settle();
			case (ph)
				0: configure(16'hFFFF, 16'hFFFF, 16'h000F, 16'h0001);
				1: configure(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
				2: configure(16'h0000, 16'hFFFF, 16'($urandom), 16'($urandom));
				3: configure(16'hFFFF, 16'h0000, 16'($urandom), 16'($urandom));
				default: configure(16'($urandom | $urandom), 16'($urandom | $urandom),
					16'($urandom), 16'($urandom));
			endcase
			send_busy = (ph != 0 && ph != 2 && ph != 5);
			recv_busy = (ph != 0 && ph != 1 && ph != 5);
			for (int k = 0; k < 190; k++) begin
				pick = $urandom_range(0, 99);
				if (pick < 40)      c = CMD_RAISE;
				else if (pick < 80) c = CMD_RESOLVE;
				else if (pick < 92) c = CMD_WRITE_ISR;
				else                c = CMD_SPARE;
				src = 16'($urandom);
				case ($urandom_range(0, 4))
					0: ;
					1: src = src & 16'h00FF;
					2: src = src & 16'hFF00;
					3: src = 16'h0001 << $urandom_range(0, 15);
					default: src = '0;
				endcase
				// in-service mostly cleared or sparse so vectored delivery stays reachable
				case ($urandom_range(0, 4))
					0, 1: sv = '0;
					2, 3: sv = 16'h0001 << $urandom_range(0, 15);
					default: sv = 16'($urandom);
				endcase
				send_word(c, src, $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0,
					3'($urandom_range(0, 7)), sv);
			end
		end

		settle();
		repeat (10) @(posedge clk);
		$display("Covered %0d words under %0d register settings, %0d results checked",
			sb.n_words, n_settings, sb.checked);
		$display("Deliveries: %0d vectored, %0d vsync, %0d hsync",
			sb.n_periph, sb.n_vsync, sb.n_hsync);
		if (sb.errors == 0 && sb.expected_q.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
